// ----- sv/satc_pkg.sv -----
// Shared types and constants of the set-associative cache tag controller.
// Used by satc_req, satc_lookup, the top level and the checker.
package satc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 5;
  localparam int unsigned LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INVAL = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  // one line lookup handed from the request stage to the tag stage
  typedef struct packed {
    logic valid;
    logic write;
    logic last;
  } issue_t;

  // tag stage state seen by the request stage
  typedef struct packed {
    logic clearing;
    logic pending;
  } lkup_status_t;

  // status flags of one lookup result
  typedef struct packed {
    logic hit;
    logic allocated;
    logic evicted_clean;
    logic evicted_dirty;
    logic made_dirty;
    logic last;
  } res_flags_t;

  // fibonacci lfsr, taps 16,14,13,11, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

endpackage

// ----- sv/satc_req.sv -----
// Request stage: decodes a command word, splits line-crossing accesses
// into two line lookups and hands invalidate-all to the tag stage. Uses satc_pkg.
module satc_req #(
  parameter int unsigned NUM_SETS   = 128,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [1:0]                      opcode_i,
  input  logic [satc_pkg::ADDR_W-1:0]     address_i,
  input  logic [satc_pkg::SIZE_W-1:0]     size_i,
  input  satc_pkg::lkup_status_t          status_i,
  output logic                            busy_o,
  output satc_pkg::issue_t                issue_o,
  output logic [$clog2(NUM_SETS)-1:0]     issue_set_o,
  output logic [satc_pkg::ADDR_W-$clog2(LINE_BYTES)-$clog2(NUM_SETS)-1:0] issue_tag_o,
  output logic                            inv_start_o
);
  import satc_pkg::*;

  localparam int unsigned OFFSET_W = $clog2(LINE_BYTES);
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned LINE_W   = ADDR_W - OFFSET_W;

  opcode_e           op;
  logic              accept;
  logic [ADDR_W-1:0] size_ext;
  logic [ADDR_W-1:0] size_sat;
  logic [ADDR_W-1:0] last_byte;
  logic [LINE_W-1:0] first_line;
  logic [LINE_W-1:0] last_line;
  logic              load;
  logic              issue_done;
  logic              inv_go;
  logic [LINE_W-1:0] issue_line;

  logic              req_valid_q, req_half_q;
  logic              req_inv_q, req_split_q, req_write_q;
  logic [LINE_W-1:0] req_line0_q, req_line1_q;

  // command decode and line split
  always_comb begin
    op       = opcode_e'(opcode_i);
    size_ext = ADDR_W'(size_i);
    priority if (size_i == '0) begin
      size_sat = ADDR_W'(1);
    end else if (size_ext > ADDR_W'(LINE_BYTES)) begin
      size_sat = ADDR_W'(LINE_BYTES);
    end else begin
      size_sat = size_ext;
    end
    last_byte  = address_i + (size_sat - ADDR_W'(1));
    first_line = address_i[ADDR_W-1:OFFSET_W];
    last_line  = last_byte[ADDR_W-1:OFFSET_W];
    unique case (op)
      OP_READ, OP_WRITE, OP_INVAL: load = 1'b1;
      OP_RSVD:                     load = 1'b0;
      default:                     load = 1'b0;
    endcase
  end

  assign busy_o = status_i.clearing ||
                  (req_valid_q && (req_inv_q || (req_split_q && !req_half_q)));
  assign accept = start_i && !busy_o;

  // lookup issue, one line per cycle
  always_comb begin
    issue_o.valid = req_valid_q && !req_inv_q;
    issue_o.write = req_write_q;
    issue_o.last  = !req_split_q || req_half_q;
    issue_line    = req_half_q ? req_line1_q : req_line0_q;
  end

  assign issue_set_o = issue_line[SET_W-1:0];
  assign issue_tag_o = issue_line[LINE_W-1:SET_W];
  assign issue_done  = issue_o.valid && issue_o.last;
  assign inv_go      = req_valid_q && req_inv_q && !status_i.pending;
  assign inv_start_o = inv_go;

  // request control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      req_half_q  <= 1'b0;
    end else begin
      priority if (accept && load) begin
        req_valid_q <= 1'b1;
        req_half_q  <= 1'b0;
      end else if (issue_done || inv_go) begin
        req_valid_q <= 1'b0;
      end else if (issue_o.valid) begin
        req_half_q <= 1'b1;
      end
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (accept && load) begin
      req_inv_q   <= (op == OP_INVAL);
      req_write_q <= (op == OP_WRITE);
      req_split_q <= (first_line != last_line);
      req_line0_q <= first_line;
      req_line1_q <= last_line;
    end
  end

endmodule

// ----- sv/satc_lookup.sv -----
// Tag stage: tag/valid/dirty memory, hit and victim selection, replacement
// lfsr and the clearing sweep after reset and invalidate-all. Uses satc_pkg.
module satc_lookup #(
  parameter int unsigned NUM_SETS   = 128,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  satc_pkg::issue_t                issue_i,
  input  logic [$clog2(NUM_SETS)-1:0]     issue_set_i,
  input  logic [satc_pkg::ADDR_W-$clog2(LINE_BYTES)-$clog2(NUM_SETS)-1:0] issue_tag_i,
  input  logic                            inv_start_i,
  output satc_pkg::lkup_status_t          status_o,
  output logic                            res_valid_o,
  output satc_pkg::res_flags_t            res_flags_o,
  output logic [$clog2(NUM_SETS)-1:0]     res_set_o,
  output logic [$clog2(NUM_WAYS)-1:0]     res_way_o
);
  import satc_pkg::*;

  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam int unsigned TAG_W = ADDR_W - $clog2(LINE_BYTES) - SET_W;

  typedef struct packed {
    logic [NUM_WAYS-1:0]            valid;
    logic [NUM_WAYS-1:0]            dirty;
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
  } row_t;

  row_t mem_q [NUM_SETS];
  row_t rd_q;
  row_t fwd_row_q;
  row_t cur_row;
  row_t new_row;

  issue_t             lk_q;
  logic [SET_W-1:0]   lk_set_q;
  logic [TAG_W-1:0]   lk_tag_q;
  logic               fwd_valid_q;
  logic [SET_W-1:0]   fwd_set_q;
  logic [LFSR_W-1:0]  lfsr_q;
  logic [LFSR_W-1:0]  lfsr_next;
  logic               clr_q;
  logic [SET_W-1:0]   clr_cnt_q;

  logic [NUM_WAYS-1:0] hit_vec;
  logic                hit;
  logic                any_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    way;
  logic                ev_clean, ev_dirty, made_dirty;
  logic                mem_we;
  logic [SET_W-1:0]    mem_waddr;
  row_t                mem_wdata;

  // set memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[issue_set_i];
  end

  // bypass the row written in the previous cycle
  assign cur_row   = (fwd_valid_q && (fwd_set_q == lk_set_q)) ? fwd_row_q : rd_q;
  assign lfsr_next = lfsr_step(lfsr_q);

  // hit search and victim choice
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      hit_vec[w] = cur_row.valid[w] && (cur_row.tag[w] == lk_tag_q);
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!cur_row.valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
    hit      = |hit_vec;
    any_free = ~&cur_row.valid;
    priority if (hit) begin
      way = hit_way;
    end else if (any_free) begin
      way = free_way;
    end else begin
      way = lfsr_next[WAY_W-1:0];
    end
  end

  // row update and result flags
  always_comb begin
    new_row  = cur_row;
    ev_clean = !hit && cur_row.valid[way] && !cur_row.dirty[way];
    ev_dirty = !hit && cur_row.valid[way] && cur_row.dirty[way];
    if (!hit) begin
      new_row.valid[way] = 1'b1;
      new_row.dirty[way] = 1'b0;
      new_row.tag[way]   = lk_tag_q;
    end
    made_dirty = lk_q.write && !new_row.dirty[way];
    if (lk_q.write) begin
      new_row.dirty[way] = 1'b1;
    end
  end

  // write port shared by lookups and the clearing sweep
  assign mem_we    = lk_q.valid || clr_q;
  assign mem_waddr = clr_q ? clr_cnt_q : lk_set_q;
  assign mem_wdata = clr_q ? row_t'('0) : new_row;

  // lookup stage, bypass, lfsr and sweep control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_q        <= '0;
      fwd_valid_q <= 1'b0;
      lfsr_q      <= LFSR_SEED;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      lk_q        <= issue_i;
      fwd_valid_q <= lk_q.valid;
      if (lk_q.valid && !hit && !any_free) begin
        lfsr_q <= lfsr_next;
      end
      priority if (inv_start_i) begin
        clr_q     <= 1'b1;
        clr_cnt_q <= '0;
      end else if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + SET_W'(1);
        if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // lookup payload
  always_ff @(posedge clk_i) begin
    lk_set_q  <= issue_set_i;
    lk_tag_q  <= issue_tag_i;
    fwd_set_q <= lk_set_q;
    fwd_row_q <= new_row;
  end

  assign status_o.clearing = clr_q;
  assign status_o.pending  = lk_q.valid;

  assign res_valid_o               = lk_q.valid;
  assign res_flags_o.hit           = hit;
  assign res_flags_o.allocated     = !hit;
  assign res_flags_o.evicted_clean = ev_clean;
  assign res_flags_o.evicted_dirty = ev_dirty;
  assign res_flags_o.made_dirty    = made_dirty;
  assign res_flags_o.last          = lk_q.last;
  assign res_set_o                 = lk_set_q;
  assign res_way_o                 = way;

endmodule

// ----- sv/set_associative_cache_tag_controller.sv -----
// Top level of the set-associative write-back cache tag controller.
// Instantiates satc_req and satc_lookup and holds the result register; uses satc_pkg.
//
//   channel   | handshake             | payload
//   ----------+-----------------------+------------------------------------------
//   command   | start_i / busy_o      | opcode_i, address_i, size_i
//   result    | result_valid_o strobe | hit_o allocated_o evicted_clean_o
//             |                       | evicted_dirty_o made_dirty_o set_index_o
//             |                       | way_index_o last_o
//
// A read or write within one line needs one tag lookup; one that crosses a line
// boundary needs two, issued through the single read-modify-write port of the set
// memory, and busy_o holds the command port off while the first is issued. The
// first result passes the request, tag stage and result registers before it is on
// the ports; a split access gives its two results back to back. Invalidate-all and
// reset sweep the set memory one set per cycle; busy_o stays high while the sweep
// runs and, after an invalidate, also while a lookup is still in the tag stage. The
// result side cannot stall; each result is shown for exactly one cycle.
module set_associative_cache_tag_controller #(
  parameter int unsigned NUM_SETS   = 128,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned LINE_BYTES = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      opcode_i,
  input  logic [satc_pkg::ADDR_W-1:0]     address_i,
  input  logic [satc_pkg::SIZE_W-1:0]     size_i,
  output logic                            result_valid_o,
  output logic                            hit_o,
  output logic                            allocated_o,
  output logic                            evicted_clean_o,
  output logic                            evicted_dirty_o,
  output logic                            made_dirty_o,
  output logic [$clog2(NUM_SETS)-1:0]     set_index_o,
  output logic [$clog2(NUM_WAYS)-1:0]     way_index_o,
  output logic                            last_o
);
  import satc_pkg::*;

  localparam int unsigned SET_W = $clog2(NUM_SETS);
  localparam int unsigned WAY_W = $clog2(NUM_WAYS);
  localparam int unsigned TAG_W = ADDR_W - $clog2(LINE_BYTES) - SET_W;

  issue_t           issue;
  logic [SET_W-1:0] issue_set;
  logic [TAG_W-1:0] issue_tag;
  logic             inv_start;
  lkup_status_t     status;
  logic             res_valid;
  res_flags_t       res_flags;
  logic [SET_W-1:0] res_set;
  logic [WAY_W-1:0] res_way;

  logic             out_valid_q;
  res_flags_t       out_flags_q;
  logic [SET_W-1:0] out_set_q;
  logic [WAY_W-1:0] out_way_q;

  satc_req #(
    .NUM_SETS   (NUM_SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_req (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .opcode_i    (opcode_i),
    .address_i   (address_i),
    .size_i      (size_i),
    .status_i    (status),
    .busy_o      (busy_o),
    .issue_o     (issue),
    .issue_set_o (issue_set),
    .issue_tag_o (issue_tag),
    .inv_start_o (inv_start)
  );

  satc_lookup #(
    .NUM_SETS   (NUM_SETS),
    .NUM_WAYS   (NUM_WAYS),
    .LINE_BYTES (LINE_BYTES)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .issue_set_i (issue_set),
    .issue_tag_i (issue_tag),
    .inv_start_i (inv_start),
    .status_o    (status),
    .res_valid_o (res_valid),
    .res_flags_o (res_flags),
    .res_set_o   (res_set),
    .res_way_o   (res_way)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= res_valid;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_flags_q <= res_flags;
      out_set_q   <= res_set;
      out_way_q   <= res_way;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign hit_o           = out_flags_q.hit;
  assign allocated_o     = out_flags_q.allocated;
  assign evicted_clean_o = out_flags_q.evicted_clean;
  assign evicted_dirty_o = out_flags_q.evicted_dirty;
  assign made_dirty_o    = out_flags_q.made_dirty;
  assign last_o          = out_flags_q.last;
  assign set_index_o     = out_set_q;
  assign way_index_o     = out_way_q;

endmodule

// ----- sv/satc_checker.sv -----
// Port-level checker of the cache tag controller, bound to the top level.
// Uses satc_pkg for opcode names.
module satc_checker #(
  parameter int unsigned NUM_SETS = 128
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [1:0]                  opcode_i,
  input logic                        result_valid_o,
  input logic                        hit_o,
  input logic                        allocated_o,
  input logic                        evicted_clean_o,
  input logic                        evicted_dirty_o,
  input logic [$clog2(NUM_SETS)-1:0] set_index_o,
  input logic                        last_o
);
  import satc_pkg::*;

  localparam int unsigned SET_W = $clog2(NUM_SETS);

  logic cmd_rw;
  logic cmd_inval;

  assign cmd_rw    = start_i && !busy_o &&
                     ((opcode_i == OP_READ) || (opcode_i == OP_WRITE));
  assign cmd_inval = start_i && !busy_o && (opcode_i == OP_INVAL);

  // a read or write gives its first word after the request, tag stage and result registers
  a_rw_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_rw |-> ##3 result_valid_o)
    else $error("read/write gave no result word after three cycles");

  // second half of a split access follows at once in the next set
  a_split_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      result_valid_o && (set_index_o == SET_W'($past(set_index_o) + SET_W'(1))))
    else $error("second lookup of a split access missing or in wrong set");

  // eviction only on allocation, never both kinds, allocation only on a miss
  a_alloc_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (allocated_o == !hit_o) &&
      !(evicted_clean_o && evicted_dirty_o) &&
      (!(evicted_clean_o || evicted_dirty_o) || allocated_o))
    else $error("inconsistent hit/allocation/eviction flags");

  // invalidate-all holds the command port off while the sweep runs
  a_inval_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_inval |=> busy_o)
    else $error("command port free right after invalidate-all");

endmodule

bind set_associative_cache_tag_controller satc_checker #(
  .NUM_SETS (NUM_SETS)
) u_satc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .opcode_i        (opcode_i),
  .result_valid_o  (result_valid_o),
  .hit_o           (hit_o),
  .allocated_o     (allocated_o),
  .evicted_clean_o (evicted_clean_o),
  .evicted_dirty_o (evicted_dirty_o),
  .set_index_o     (set_index_o),
  .last_o          (last_o)
);

// ----- test/tb_top.sv -----
// Self-checking bench for the set-associative cache tag controller.
// Predicts every line lookup from a shadow copy of tags, valid/dirty bits and the lfsr;
// depends on satc_pkg and set_associative_cache_tag_controller.
`timescale 1ns / 1ps

module tb_top;
  import satc_pkg::*;

  localparam int unsigned NUM_SETS     = 128;
  localparam int unsigned NUM_WAYS     = 4;
  localparam int unsigned LINE_BYTES   = 16;
  localparam int unsigned OFF_BITS     = 4;
  localparam int unsigned SET_BITS     = 7;
  localparam int unsigned TAG_BITS     = ADDR_W - OFF_BITS - SET_BITS;
  localparam int unsigned SLOTS        = NUM_SETS * NUM_WAYS;
  localparam int unsigned RANDOM_WORDS = 600;
  localparam int unsigned LIMIT_CYCLES = 400000;

  // one expected lookup result
  typedef struct packed {
    logic                hit;
    logic                allocated;
    logic                evicted_clean;
    logic                evicted_dirty;
    logic                made_dirty;
    logic [SET_BITS-1:0] set_index;
    logic [1:0]          way_index;
    logic                last;
  } lookup_word_t;

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  start_i   = 1'b0;
  logic [1:0]            opcode_i  = OP_READ;
  logic [ADDR_W-1:0]     address_i = '0;
  logic [SIZE_W-1:0]     size_i    = 5'd1;
  logic                  busy_o;
  logic                  result_valid_o;
  logic                  hit_o;
  logic                  allocated_o;
  logic                  evicted_clean_o;
  logic                  evicted_dirty_o;
  logic                  made_dirty_o;
  logic [SET_BITS-1:0]   set_index_o;
  logic [1:0]            way_index_o;
  logic                  last_o;

  // shadow cache state
  logic [TAG_BITS-1:0]   shadow_tag   [SLOTS];
  logic                  shadow_valid [SLOTS];
  logic                  shadow_dirty [SLOTS];
  logic [LFSR_W-1:0]     shadow_lfsr;

  lookup_word_t          pending_lookups [$];
  lookup_word_t          seen_word;
  lookup_word_t          due_word;
  int unsigned           mismatch_count = 0;
  int unsigned           words_checked  = 0;
  int unsigned           cycle_count    = 0;
  int unsigned           burst_left     = 0;
  logic [TAG_BITS-1:0]   tag_pool [6];

  set_associative_cache_tag_controller #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .size_i         (size_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .allocated_o    (allocated_o),
    .evicted_clean_o(evicted_clean_o),
    .evicted_dirty_o(evicted_dirty_o),
    .made_dirty_o   (made_dirty_o),
    .set_index_o    (set_index_o),
    .way_index_o    (way_index_o),
    .last_o         (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h (word %0d, cycle %0d)",
             what, got, want, words_checked, cycle_count);
    mismatch_count++;
  endtask

  // one line lookup against the shadow state
  function automatic void predict_lookup(input logic [ADDR_W-OFF_BITS-1:0] line_no,
                                         input logic is_write, input logic is_last);
    lookup_word_t        w;
    int unsigned         base;
    int unsigned         i;
    logic [1:0]          way;
    logic                found;
    logic [TAG_BITS-1:0] tag;
    logic [LFSR_W-1:0]   s;
    w     = '0;
    way   = 2'd0;
    found = 1'b0;
    tag   = line_no[ADDR_W-OFF_BITS-1:SET_BITS];
    base  = line_no[SET_BITS-1:0] * NUM_WAYS;
    w.set_index = line_no[SET_BITS-1:0];
    for (i = 0; i < NUM_WAYS; i++) begin
      if (!found && shadow_valid[base+i] && shadow_tag[base+i] == tag) begin
        found = 1'b1;
        way   = i[1:0];
      end
    end
    w.hit = found;
    if (!found) begin
      // lowest free way, else a random victim
      for (i = 0; i < NUM_WAYS; i++) begin
        if (!found && !shadow_valid[base+i]) begin
          found = 1'b1;
          way   = i[1:0];
        end
      end
      if (!found) begin
        s           = shadow_lfsr;
        shadow_lfsr = {s[0] ^ s[2] ^ s[3] ^ s[5], s[LFSR_W-1:1]};
        way         = shadow_lfsr[1:0];
      end
      if (shadow_valid[base+way]) begin
        w.evicted_dirty = shadow_dirty[base+way];
        w.evicted_clean = !shadow_dirty[base+way];
      end
      w.allocated             = 1'b1;
      shadow_valid[base+way]  = 1'b1;
      shadow_dirty[base+way]  = 1'b0;
      shadow_tag[base+way]    = tag;
    end
    if (is_write) begin
      w.made_dirty           = !shadow_dirty[base+way];
      shadow_dirty[base+way] = 1'b1;
    end
    w.way_index = way;
    w.last      = is_last;
    pending_lookups.push_back(w);
  endfunction

  // whole request: split, saturate, wrap, invalidate
  function automatic void predict_request(input opcode_e op, input logic [ADDR_W-1:0] addr,
                                          input logic [SIZE_W-1:0] size);
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] last_byte;
    int unsigned       i;
    case (op)
      OP_INVAL: begin
        for (i = 0; i < SLOTS; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_dirty[i] = 1'b0;
        end
      end
      OP_RSVD: begin
      end
      default: begin
        span = ADDR_W'(size);
        if (span == 0) span = 1;
        if (span > LINE_BYTES) span = LINE_BYTES;
        last_byte = addr + span - 1;
        if (addr[ADDR_W-1:OFF_BITS] == last_byte[ADDR_W-1:OFF_BITS]) begin
          predict_lookup(addr[ADDR_W-1:OFF_BITS], op == OP_WRITE, 1'b1);
        end else begin
          predict_lookup(addr[ADDR_W-1:OFF_BITS], op == OP_WRITE, 1'b0);
          predict_lookup(last_byte[ADDR_W-1:OFF_BITS], op == OP_WRITE, 1'b1);
        end
      end
    endcase
  endfunction

  // random idle between words, mostly short, some long, none during a burst
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (burst_left > 0) burst_left--;
    else if (r >= 55 && r < 90) n = $urandom_range(1, 3);
    else if (r >= 90) n = $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // send one command word and record its expected lookups
  task automatic send_word(input opcode_e op, input logic [ADDR_W-1:0] addr,
                           input logic [SIZE_W-1:0] size);
    opcode_i  <= op;
    address_i <= addr;
    size_i    <= size;
    start_i   <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predict_request(op, addr, size);
    idle_gap();
  endtask

  // hold the command side until every expected word is back
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      seen_word = {hit_o, allocated_o, evicted_clean_o, evicted_dirty_o, made_dirty_o,
                   set_index_o, way_index_o, last_o};
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected word", 32'(seen_word), '0);
      end else begin
        due_word = pending_lookups.pop_front();
        if (seen_word.hit !== due_word.hit)
          report_mismatch("hit", 32'(seen_word.hit), 32'(due_word.hit));
        if (seen_word.allocated !== due_word.allocated)
          report_mismatch("allocated", 32'(seen_word.allocated), 32'(due_word.allocated));
        if (seen_word.evicted_clean !== due_word.evicted_clean)
          report_mismatch("evicted_clean", 32'(seen_word.evicted_clean),
                          32'(due_word.evicted_clean));
        if (seen_word.evicted_dirty !== due_word.evicted_dirty)
          report_mismatch("evicted_dirty", 32'(seen_word.evicted_dirty),
                          32'(due_word.evicted_dirty));
        if (seen_word.made_dirty !== due_word.made_dirty)
          report_mismatch("made_dirty", 32'(seen_word.made_dirty), 32'(due_word.made_dirty));
        if (seen_word.set_index !== due_word.set_index)
          report_mismatch("set_index", 32'(seen_word.set_index), 32'(due_word.set_index));
        if (seen_word.way_index !== due_word.way_index)
          report_mismatch("way_index", 32'(seen_word.way_index), 32'(due_word.way_index));
        if (seen_word.last !== due_word.last)
          report_mismatch("last", 32'(seen_word.last), 32'(due_word.last));
      end
      words_checked++;
    end
  end

  // miss then hits, clean line turned dirty once
  task automatic test_hit_miss();
    send_word(OP_READ,  32'h0000_1000, 5'd4);
    send_word(OP_READ,  32'h0000_1004, 5'd4);
    send_word(OP_WRITE, 32'h0000_1008, 5'd1);
    send_word(OP_WRITE, 32'h0000_100F, 5'd1);
  endtask

  // fill one set with dirty lines, then force a random dirty victim
  task automatic test_eviction();
    int unsigned t;
    for (t = 1; t <= 5; t++) begin
      send_word((t < 5) ? OP_WRITE : OP_READ,
                {t[TAG_BITS-1:0], 7'd5, 4'd0}, 5'd8);
    end
  endtask

  // line crossing, size zero, saturated size, full line
  task automatic test_size_split();
    send_word(OP_READ,  32'h0002_000F, 5'd2);
    send_word(OP_WRITE, 32'h0000_3000, 5'd0);
    send_word(OP_READ,  32'h0000_3001, 5'd31);
    send_word(OP_WRITE, 32'h0000_4000, 5'd16);
  endtask

  // top of memory wraps to line zero
  task automatic test_address_wrap();
    send_word(OP_READ,  32'hFFFF_FFFF, 5'd2);
    send_word(OP_WRITE, 32'hFFFF_FFF0, 5'd16);
  endtask

  // reserved opcode ignored, invalidate clears everything
  task automatic test_opcodes();
    send_word(OP_RSVD,  32'h0000_1000, 5'd4);
    send_word(OP_INVAL, 32'h0000_0000, 5'd1);
    send_word(OP_READ,  32'h0000_1000, 5'd4);
    wait_drained();
    send_word(OP_WRITE, 32'hFFFF_FFFF, 5'd31);
  endtask

  // random traffic over a few hot sets and tags, with noise
  task automatic test_random_traffic();
    int unsigned      sent;
    int unsigned      r;
    opcode_e          op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (r = 2; r < 6; r++) tag_pool[r] = TAG_BITS'($urandom());
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 48) op = OP_READ;
      else if (r < 94) op = OP_WRITE;
      else if (r < 97) op = OP_INVAL;
      else op = OP_RSVD;
      r = $urandom_range(0, 99);
      if (r < 15) addr = $urandom();
      else if (r < 18) addr = 32'hFFFF_FFF0 | ADDR_W'($urandom_range(0, 15));
      else addr = {tag_pool[$urandom_range(0, 5)],
                   (r < 70) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15))};
      if ($urandom_range(0, 99) < 85) size = SIZE_W'($urandom_range(1, 16));
      else size = SIZE_W'($urandom_range(0, 31));
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(20, 60);
      send_word(op, addr, size);
      if (op != OP_RSVD) sent++;
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  // main sequence
  initial begin
    int unsigned i;
    for (i = 0; i < SLOTS; i++) begin
      shadow_tag[i]   = '0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
    end
    shadow_lfsr = LFSR_SEED;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_hit_miss();
    test_eviction();
    test_size_split();
    test_address_wrap();
    test_opcodes();
    test_random_traffic();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_lookups.size() != 0)
      report_mismatch("words never returned", 0, pending_lookups.size());
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
